### design/plce_pkg.sv
// ----------------------------------------------------------------------------
// plce_pkg: shared types and constants of the piecewise-linear curve evaluator
// Field widths, operation and register codes, and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package plce_pkg;

  localparam int POS_W     = 32;  // signed Q16.16 position
  localparam int VAL_W     = 16;  // unsigned curve value
  localparam int CNT_W     = 5;   // point_count register
  localparam int IDX_IN_W  = 4;   // point_index field
  localparam int CFG_IDX_W = 2;   // configuration register index
  localparam int DIFF_W    = POS_W + 1;      // position differences
  localparam int PROD_W    = DIFF_W + VAL_W; // value times difference
  localparam int DCNT_W    = $clog2(VAL_W);  // divider step counter

  localparam logic [VAL_W-1:0] EMPTY_VALUE_RST = 16'hFFFF;

  // operation codes of an input item
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_VALUE = 2'd1;

  typedef enum logic [1:0] {
    OUT_EMPTY = 2'd0,
    OUT_POINT = 2'd1,
    OUT_QUOT  = 2'd2
  } out_sel_e;

  typedef struct packed {
    logic     load_we;     // write the item's point into its slot
    logic     eval_start;  // latch the query, read slot 0
    logic     adv;         // current point becomes left point, read next slot
    logic     mul;         // form the weighted products and the divisor
    logic     add;         // sum the products, seed the divider
    logic     div_step;    // one quotient bit
    logic     out_en;      // present a result
    out_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic n_zero;    // no points in use
    logic n_one;     // exactly one point in use
    logic hit;       // point just read lies at or right of the query
    logic last;      // point just read is the last one in use
    logic div_last;  // divider on its final step
  } sts_t;

endpackage

### design/plce_dp.sv
// ----------------------------------------------------------------------------
// plce_dp: datapath of the curve evaluator
// Point memory, configuration registers, search registers, the product
// stage and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module plce_dp
  import plce_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VAL_W-1:0]     cfg_data_i,
  input  logic [IDX_IN_W-1:0]  point_index_i,
  input  logic [POS_W-1:0]     point_position_i,
  input  logic [VAL_W-1:0]     point_value_i,
  input  logic [POS_W-1:0]     query_position_i,
  output logic                 result_valid_o,
  output logic [VAL_W-1:0]     curve_value_o
);

  localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int AW    = (IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W;
  localparam int NB    = $clog2(MAX_POINTS + 1);
  localparam int NW    = (NB > CNT_W) ? NB : CNT_W;

  logic [POS_W-1:0] mem_pos [MAX_POINTS];
  logic [VAL_W-1:0] mem_val [MAX_POINTS];

  logic [CNT_W-1:0]  point_count_q;
  logic [VAL_W-1:0]  empty_value_q;
  logic [POS_W-1:0]  rd_pos_q, q_q, pl_q;
  logic [VAL_W-1:0]  rd_val_q, vl_q;
  logic [IDX_W-1:0]  idx_q;
  logic [PROD_W-1:0] prod_l_q, prod_r_q;
  logic [DIFF_W-1:0] den_q, rem_q, rem_d;
  logic [VAL_W-1:0]  quo_q, quo_d;
  logic [DCNT_W-1:0] div_cnt_q;
  logic              out_valid_q;
  logic [VAL_W-1:0]  out_value_q;

  logic [AW-1:0]     wr_ext;
  logic              wr_ok;
  logic [IDX_W-1:0]  rd_addr;
  logic [NW-1:0]     n_raw, n_eff;
  logic [DIFF_W-1:0] wl, wr, den;
  logic [PROD_W-1:0] num;
  logic [DIFF_W:0]   trial;
  logic [DIFF_W+1:0] sub;

  // slot decode; slots past the memory are dropped
  assign wr_ext = AW'(point_index_i);
  assign wr_ok  = ({{(32-IDX_IN_W){1'b0}}, point_index_i} < 32'(MAX_POINTS));
  assign rd_addr = cmd_i.eval_start ? '0 : (idx_q + IDX_W'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && wr_ok) begin
      mem_pos[wr_ext[IDX_W-1:0]] <= point_position_i;
      mem_val[wr_ext[IDX_W-1:0]] <= point_value_i;
    end
    if (cmd_i.eval_start || cmd_i.adv) begin
      rd_pos_q <= mem_pos[rd_addr];
      rd_val_q <= mem_val[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
      empty_value_q <= EMPTY_VALUE_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_POINT_COUNT) begin
        point_count_q <= cfg_data_i[CNT_W-1:0];
      end
      if (cfg_index_i == REG_EMPTY_VALUE) begin
        empty_value_q <= cfg_data_i;
      end
    end
  end

  // points in use, capped at the memory depth
  assign n_raw = NW'(point_count_q);
  assign n_eff = (n_raw > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : n_raw;

  assign sts_o.n_zero   = (n_eff == '0);
  assign sts_o.n_one    = (n_eff == NW'(1));
  assign sts_o.hit      = ($signed(rd_pos_q) >= $signed(q_q));
  assign sts_o.last     = ((NW'(idx_q) + NW'(1)) == n_eff);
  assign sts_o.div_last = (div_cnt_q == DCNT_W'(VAL_W - 1));

  // differences are nonnegative once the search stops: pl < q <= pr
  assign wl  = {rd_pos_q[POS_W-1], rd_pos_q} - {q_q[POS_W-1], q_q};
  assign wr  = {q_q[POS_W-1], q_q} - {pl_q[POS_W-1], pl_q};
  assign den = {rd_pos_q[POS_W-1], rd_pos_q} - {pl_q[POS_W-1], pl_q};
  assign num = prod_l_q + prod_r_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_start) begin
      q_q <= query_position_i;
    end
    if (cmd_i.adv) begin
      pl_q <= rd_pos_q;
      vl_q <= rd_val_q;
    end
    if (cmd_i.mul) begin
      prod_l_q <= PROD_W'(vl_q) * PROD_W'(wl);
      prod_r_q <= PROD_W'(rd_val_q) * PROD_W'(wr);
      den_q    <= den;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.eval_start) begin
      idx_q <= '0;
    end else if (cmd_i.adv) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  // restoring division, one quotient bit per cycle; quotient fits VAL_W bits
  assign trial = {rem_q, quo_q[VAL_W-1]};
  assign sub   = {1'b0, trial} - {2'b00, den_q};

  always_comb begin
    if (!sub[DIFF_W+1]) begin
      rem_d = sub[DIFF_W-1:0];
      quo_d = {quo_q[VAL_W-2:0], 1'b1};
    end else begin
      rem_d = trial[DIFF_W-1:0];
      quo_d = {quo_q[VAL_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      rem_q <= num[PROD_W-1:VAL_W];
      quo_q <= num[VAL_W-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.add) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.out_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_en) begin
      case (cmd_i.out_sel)
        OUT_EMPTY: out_value_q <= empty_value_q;
        OUT_POINT: out_value_q <= rd_val_q;
        OUT_QUOT:  out_value_q <= quo_q;
        default:   out_value_q <= empty_value_q;
      endcase
    end
  end

  assign result_valid_o = out_valid_q;
  assign curve_value_o  = out_value_q;

endmodule

### design/plce_ctrl.sv
// ----------------------------------------------------------------------------
// plce_ctrl: controller of the curve evaluator
// Sequences the point search, the product stage and the divider.
// ----------------------------------------------------------------------------
module plce_ctrl
  import plce_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic op_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_sel = OUT_EMPTY;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (op_i == OP_LOAD) begin
            cmd_o.load_we = 1'b1;
          end else if (sts_i.n_zero) begin
            cmd_o.out_en  = 1'b1;
            cmd_o.out_sel = OUT_EMPTY;
          end else begin
            cmd_o.eval_start = 1'b1;
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (sts_i.n_one || sts_i.hit) begin
          cmd_o.out_en  = 1'b1;
          cmd_o.out_sel = OUT_POINT;
          state_d = S_IDLE;
        end else begin
          cmd_o.adv = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          cmd_o.mul = 1'b1;
          state_d = S_ADD;
        end else if (sts_i.last) begin
          cmd_o.out_en  = 1'b1;
          cmd_o.out_sel = OUT_POINT;
          state_d = S_IDLE;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.out_en  = 1'b1;
        cmd_o.out_sel = OUT_QUOT;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### design/piecewise_linear_curve_eval.sv
// ----------------------------------------------------------------------------
// piecewise_linear_curve_eval: piecewise-linear curve lookup
// Holds up to MAX_POINTS control points and evaluates the curve at a query
// position, clamping outside the points and interpolating between them.
// ----------------------------------------------------------------------------
//
//   channel   handshake                 payload
//   -------   -----------------------   -----------------------------------
//   input     start_i, busy_o           op_i, point_index_i, point_position_i,
//                                       point_value_i, query_position_i
//   result    result_valid_o (strobe)   curve_value_o
//   config    cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//
// A load returns nothing. An evaluate with no points in use returns
// empty_value in the cycle after acceptance. Otherwise the search reads
// the points in turn from slot 0; one point in use, a query at or left of
// the first point, or a query beyond the last returns that point's value.
// A query between points takes a product step, a sum step, the divider
// steps and an output step.
// Reset clears control state and the configuration registers; the point
// memory keeps its contents and needs no clearing. Results are strobed for
// one cycle: the receiver cannot stall the block.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_eval
  import plce_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input item channel
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 op_i,
  input  logic [IDX_IN_W-1:0]  point_index_i,
  input  logic [POS_W-1:0]     point_position_i,
  input  logic [VAL_W-1:0]     point_value_i,
  input  logic [POS_W-1:0]     query_position_i,
  // result channel
  output logic                 result_valid_o,
  output logic [VAL_W-1:0]     curve_value_o,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VAL_W-1:0]     cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // registers take a write in any cycle; user writes must come only while idle
  assign cfg_ready_o = 1'b1;

  // controller: accept items, walk the search, sequence the divider
  plce_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // datapath: point memory, config registers, products and divider
  plce_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .point_index_i    (point_index_i),
    .point_position_i (point_position_i),
    .point_value_i    (point_value_i),
    .query_position_i (query_position_i),
    .result_valid_o   (result_valid_o),
    .curve_value_o    (curve_value_o)
  );

endmodule

### design/plce_checker.sv
// ----------------------------------------------------------------------------
// plce_checker: port-level checks of the curve evaluator
// Relates accepted items to the busy flag and the result strobe.
// ----------------------------------------------------------------------------
module plce_checker
  import plce_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic op_i,
  input logic result_valid_o
);

  // a load never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i == OP_LOAD) |=> !result_valid_o)
    else $error("result strobed after a load");

  // an accepted evaluate either answers at once or keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i == OP_EVAL) |=> (busy_o || result_valid_o))
    else $error("evaluate lost");

  // a result marks the end of the work: the block is idle again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result while still busy");

  // busy starts only from an accepted evaluate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && op_i == OP_EVAL))
    else $error("busy without an evaluate");

endmodule

bind piecewise_linear_curve_eval plce_checker u_plce_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .op_i           (op_i),
  .result_valid_o (result_valid_o)
);

### bench/tb_piecewise_linear_curve_eval.sv
// ----------------------------------------------------------------------------
// tb_piecewise_linear_curve_eval: self-checking bench of the curve evaluator
// Loads control points, programs the point count and the empty value, and
// evaluates the curve at queries placed on, between and beyond the points.
// A scoreboard class mirrors the point tables, predicts each evaluation and
// compares it with the strobed result.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_curve_eval
  import plce_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PTS       = 16;
  localparam int SETTLE_CYCLES = 48;         // deepest evaluate plus margin
  localparam int ITEMS_PER_PHASE = 167;      // three phases, about 500 items

  // register indexes that decode to nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the point tables and registers, plus the queue of
  // curve values still owed by the block.
  // --------------------------------------------------------------------------
  class curve_scoreboard;
    logic signed [POS_W-1:0] pos_tab [MAX_PTS];
    logic [VAL_W-1:0]        val_tab [MAX_PTS];
    logic [CNT_W-1:0]        n_points;
    logic [VAL_W-1:0]        empty_val;
    logic [VAL_W-1:0]        owed_values [$];
    int                      errors;

    function new();
      n_points  = '0;
      empty_val = EMPTY_VALUE_RST;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
      case (idx)
        REG_POINT_COUNT: n_points = data[CNT_W-1:0];
        REG_EMPTY_VALUE: empty_val = data;
        default: ;
      endcase
    endfunction

    // Clamp outside the points, else interpolate toward the first point at
    // or right of the query; the division truncates.
    function logic [VAL_W-1:0] interpolate_at(logic signed [POS_W-1:0] q);
      int     n;
      int     i;
      longint ql, pl, pr, num, den;
      n  = (n_points > MAX_PTS) ? MAX_PTS : int'(n_points);
      ql = q;
      if (n == 0) return empty_val;
      if (n == 1 || pos_tab[0] >= q) return val_tab[0];
      for (i = 1; i < n; i++) begin
        if (pos_tab[i] >= q) begin
          pl  = pos_tab[i-1];
          pr  = pos_tab[i];
          num = longint'(val_tab[i-1]) * (pr - ql) + longint'(val_tab[i]) * (ql - pl);
          den = pr - pl;
          return VAL_W'(num / den);
        end
      end
      return val_tab[n-1];
    endfunction

    function void note_item(logic op, logic [IDX_IN_W-1:0] idx,
                            logic signed [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                            logic signed [POS_W-1:0] q);
      if (op == OP_LOAD) begin
        if (idx < MAX_PTS) begin
          pos_tab[idx] = pos;
          val_tab[idx] = val;
        end
      end else begin
        owed_values.push_back(interpolate_at(q));
      end
    endfunction

    function void check_value(logic [VAL_W-1:0] got);
      logic [VAL_W-1:0] want;
      if (owed_values.size() == 0) begin
        $error("curve_value: none expected, actual %0d", got);
        errors++;
        return;
      end
      want = owed_values.pop_front();
      if (got !== want) begin
        $error("curve_value: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function void check_drained();
      if (owed_values.size() != 0) begin
        $error("curve_value: %0d results never arrived", owed_values.size());
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 start_i          = 1'b0;
  logic                 busy_o;
  logic                 op_i             = OP_LOAD;
  logic [IDX_IN_W-1:0]  point_index_i    = '0;
  logic [POS_W-1:0]     point_position_i = '0;
  logic [VAL_W-1:0]     point_value_i    = '0;
  logic [POS_W-1:0]     query_position_i = '0;
  logic                 result_valid_o;
  logic [VAL_W-1:0]     curve_value_o;
  logic                 cfg_valid_i      = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i      = '0;
  logic [VAL_W-1:0]     cfg_data_i       = '0;

  piecewise_linear_curve_eval #(
    .MAX_POINTS(MAX_PTS)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .op_i             (op_i),
    .point_index_i    (point_index_i),
    .point_position_i (point_position_i),
    .point_value_i    (point_value_i),
    .query_position_i (query_position_i),
    .result_valid_o   (result_valid_o),
    .curve_value_o    (curve_value_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  curve_scoreboard sb;

  // Stimulus-side copy of the point positions, used only to aim queries, and
  // a mask of slots that hold a loaded point. Never raise the point count over
  // a slot that was not loaded.
  logic signed [POS_W-1:0] aim_pos [MAX_PTS];
  logic [MAX_PTS-1:0]      loaded_mask = '0;
  int                      live_pts    = 0;   // points in use, after clamping
  int                      idle_pct    = 0;   // chance of a sender gap per item
  int                      items_sent  = 0;

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the block's
  // flops and the drivers' nonblocking updates land.
  // Check results before noting new items: a result never belongs to an item
  // accepted at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_value(curve_value_o);
      if (start_i && !busy_o)
        sb.note_item(op_i, point_index_i, point_position_i, point_value_i,
                     query_position_i);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one item and hold it until the block takes it. Start stays high on
  // return so back-to-back items go out without a bubble.
  task automatic send_item(logic op, logic [IDX_IN_W-1:0] idx,
                           logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                           logic [POS_W-1:0] q);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i          <= 1'b1;
    op_i             <= op;
    point_index_i    <= idx;
    point_position_i <= pos;
    point_value_i    <= val;
    query_position_i <= q;
    do @(posedge clk_i); while (busy_o);
    if (op == OP_LOAD) begin
      aim_pos[idx]     = pos;
      loaded_mask[idx] = 1'b1;
    end
    items_sent++;
  endtask

  // Unused fields carry random junk: the block must ignore them.
  task automatic load_point(int slot, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    send_item(OP_LOAD, IDX_IN_W'(slot), pos, val, $urandom);
  endtask

  task automatic eval_at(logic [POS_W-1:0] q);
    send_item(OP_EVAL, IDX_IN_W'($urandom), $urandom, VAL_W'($urandom), q);
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic wait_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.owed_values.size() != 0);
  endtask

  // Loads leave no result behind, so give the block time to finish one after
  // the queue empties; registers are written only then.
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Program the point count with junk in the unused upper data bits.
  task automatic set_point_count(int n);
    logic [VAL_W-1:0] data;
    data            = VAL_W'($urandom);
    data[CNT_W-1:0] = CNT_W'(n);
    set_reg(REG_POINT_COUNT, data);
    live_pts = (n > MAX_PTS) ? MAX_PTS : n;
  endtask

  // --------------------------------------------------------------------------
  // Random content
  // --------------------------------------------------------------------------
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Aim most queries at or next to points and inside segments; the rest land
  // anywhere or on the range ends.
  function automatic logic [POS_W-1:0] pick_query();
    int     r, j;
    longint lo, hi;
    r = $urandom_range(0, 99);
    if (live_pts == 0 || r < 15) return $urandom;
    if (r < 25) begin
      case ($urandom_range(0, 4))
        0:       return POS_MIN;
        1:       return POS_MIN + 1;
        2:       return POS_MAX;
        3:       return '1;
        default: return '0;
      endcase
    end
    if (r < 60 || live_pts < 2) begin
      j = $urandom_range(0, live_pts - 1);
      return aim_pos[j] + POS_W'($urandom_range(0, 4)) - POS_W'(2);
    end
    j  = $urandom_range(0, live_pts - 2);
    lo = aim_pos[j];
    hi = aim_pos[j+1];
    if (hi <= lo) return POS_W'(lo);
    return POS_W'(lo + longint'($urandom_range(0, 32'(hi - lo))));
  endfunction

  // Load slots 0 to k-1: ascending with a random spacing (repeats allowed),
  // or scattered at random as noise.
  task automatic build_curve(int k, bit ascending);
    longint p, span;
    case ($urandom_range(0, 2))
      0:       span = 4;
      1:       span = 64'h0002_0000;
      default: span = 64'h0800_0000;
    endcase
    if ($urandom_range(0, 4) == 0) p = POS_MIN;
    else p = longint'($signed($urandom));
    if (p > longint'(POS_MAX) - k * span) p = longint'(POS_MAX) - k * span;
    for (int j = 0; j < k; j++) begin
      if (!ascending) load_point(j, $urandom, pick_value());
      else if (j == k - 1 && $urandom_range(0, 4) == 0) load_point(j, POS_MAX, pick_value());
      else load_point(j, POS_W'(p), pick_value());
      p += longint'($urandom_range(0, 32'(span)));
    end
  endtask

  // One curve: load it, program the registers, then evaluate it, with a few
  // stray loads and full drains mixed in.
  task automatic run_curve();
    int n, r, slot;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < 8)       n = 0;
    else if (r < 16) n = 1;
    else if (r < 26) n = $urandom_range(MAX_PTS + 1, 31);   // count too large
    else             n = $urandom_range(2, MAX_PTS);
    build_curve((n > MAX_PTS) ? MAX_PTS : n, $urandom_range(0, 99) >= 15);
    set_point_count(n);
    if ($urandom_range(0, 2) == 0) set_reg(REG_EMPTY_VALUE, pick_value());
    if ($urandom_range(0, 5) == 0)
      set_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, VAL_W'($urandom));
    repeat ($urandom_range(6, 20)) begin
      if ($urandom_range(0, 99) < 4) wait_results();
      if ($urandom_range(0, 99) < 12) begin
        slot = $urandom_range(0, MAX_PTS - 1);
        pos  = (loaded_mask[slot] && $urandom_range(0, 1)) ? aim_pos[slot] : $urandom;
        load_point(slot, pos, pick_value());
      end else begin
        eval_at(pick_query());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int target;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: no points with the reset empty value, then a cleared one.
    eval_at(POS_MIN);
    set_reg(REG_EMPTY_VALUE, 16'h0000);
    eval_at(POS_MAX);

    // Points at the low end, in the middle (twice, equal positions) and above.
    load_point(0, POS_MIN, 16'hFFFF);
    load_point(1, 32'h0000_0000, 16'h8000);
    load_point(2, 32'h0000_0000, 16'h0001);
    load_point(3, 32'h0001_0000, 16'h0000);

    // A single point answers every query.
    set_point_count(1);
    eval_at(32'h0000_0000);

    // Two points: on the first, just right of it, inside, on the second.
    set_point_count(2);
    eval_at(POS_MIN);
    eval_at(POS_MIN + 1);
    eval_at(32'hFFFF_FFFF);
    eval_at(32'h0000_0000);

    // Four points with a repeated position; beyond the last clamps.
    set_point_count(4);
    eval_at(32'h0000_0001);
    eval_at(32'h0001_0000);
    eval_at(POS_MAX);
    set_point_count(3);
    eval_at(POS_MAX);

    // Positions out of order: the search still runs left to right.
    load_point(3, POS_MIN, 16'h1234);
    set_point_count(4);
    eval_at(32'h0000_0005);

    // Widest segment: the full position range in one divisor.
    load_point(1, POS_MAX, 16'h0000);
    set_point_count(2);
    eval_at(32'h0000_0000);
    eval_at(POS_MAX - 1);
    set_reg(REG_SPARE_A, 16'hFFFF);
    set_reg(REG_SPARE_B, 16'h5A5A);
    set_reg(REG_EMPTY_VALUE, 16'hFFFF);
    eval_at(32'h4000_0000);

    // Random curves: sender gaps 38 %, then 57 %, then none.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 38 : (phase == 1) ? 57 : 0;
      target   = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) run_curve();
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.check_drained();
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
